// ===== sv/assert_macros.svh =====
// Assertion macros shared by the bounding sphere unit.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define BSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define BSU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/bsu_pkg.sv =====
// Package of the bounding sphere unit: request and result types, command
// and status structs between controller and datapath. No dependencies.
package bsu_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		FN_LOAD      = 2'd0,
		FN_ENCAP     = 2'd1,
		FN_INTERSECT = 2'd2,
		FN_CONTAIN   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MUL_SQ   = 2'd0,
		MUL_MOVE = 2'd1,
		MUL_RSQ  = 2'd2
	} mul_sel_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic [30:0]        load_radius;
	} item_t;

	typedef struct packed {
		logic               test_flag;
		logic signed [31:0] out_center_x;
		logic signed [31:0] out_center_y;
		logic signed [31:0] out_center_z;
		logic [30:0]        out_radius;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       acc_en;
		mul_sel_t   mul_sel;
		logic [1:0] axis;
		logic       flag_en;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       move_en;
		logic       load_sphere;
		logic       rad_update;
		logic       rsq_wr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  grow;
	} status_t;

endpackage

// ===== sv/bounding_sphere_unit.sv =====
// Bounding sphere unit: keeps one sphere in signed fixed point and runs one request
// at a time: load, grow to take in a point, box intersect test, box contain test.
// A growing encapsulate runs a square root retiring one root bit a cycle, then per
// axis a multiply, a divider load, a restoring divider retiring one quotient bit a
// cycle and a centre update. A finished result waits while the last one is stalled.
// The next request is taken only once result valid has risen.
// Depends on bsu_pkg, bsu_ctrl, bsu_datapath and assert_macros.svh.
`include "assert_macros.svh"
module bounding_sphere_unit import bsu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);
	localparam logic [30:0] RMAX31 = 31'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

	cmd_t    cmd;
	status_t stat;

	bsu_ctrl #(.CW(COORD_WIDTH)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	bsu_datapath #(.CW(COORD_WIDTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	`BSU_ASSERT(a_busy_after_request, item_valid && !item_stall |=> item_stall, "request not held")
	`BSU_ASSERT(a_result_on_idle, $fell(item_stall) |-> result_valid, "no result at finish")
	`BSU_NEVER(a_radius_range, result_valid && result.out_radius > RMAX31, "radius out of range")

endmodule

// ===== sv/bsu_datapath.sv =====
// Datapath of the bounding sphere unit: sphere state, shared multiplier,
// accumulator, square root and divider. Depends on bsu_pkg.
module bsu_datapath import bsu_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output status_t stat,
	output result_t result
);
	localparam int AW  = 2 * CW + 2;
	localparam int PW  = 2 * CW + 1;
	localparam int SRW = CW + 4;
	localparam int DRW = CW + 3;
	localparam logic [30:0] RMAX31 = 31'((64'd1 << (CW - 1)) - 64'd1);

	func_t               func_q;
	logic signed [CW-1:0] p_q [3];
	logic signed [CW-1:0] m_q [3];
	logic [30:0]         lr_q;
	logic signed [CW-1:0] c_q [3];
	logic [CW-2:0]       radius_q;
	logic [2*CW-3:0]     rsq_q;
	logic [AW-1:0]       acc_q;
	logic [PW-1:0]       prod_q;
	logic [SRW-1:0]      srem_q;
	logic [CW:0]         root_q;
	logic [AW-1:0]       src_q;
	logic [DRW-1:0]      drem_q;
	logic [CW-1:0]       dsrc_q;
	logic [CW-1:0]       quo_q;
	logic                flag_q;
	result_t             result_q;

	logic signed [CW-1:0] ck, pk, mk;
	logic signed [CW:0]   diff, cm, newc;
	logic [CW:0]          dneg, cmneg;
	logic [CW-1:0]        dmag, cmmag, sqmag, ma;
	logic [CW:0]          mb, num;
	logic [SRW-1:0]       srn, strial;
	logic [DRW-1:0]       drn, dden;
	logic [CW+1:0]        sumlr;
	logic [CW:0]          half;
	logic [CW-2:0]        nr, lr_sat;

	always_comb begin
		ck    = c_q[cmd.axis];
		pk    = p_q[cmd.axis];
		mk    = m_q[cmd.axis];
		diff  = {pk[CW-1], pk} - {ck[CW-1], ck};
		cm    = {ck[CW-1], ck} - {mk[CW-1], mk};
		dneg  = -diff;
		cmneg = -cm;
		dmag  = diff[CW] ? dneg[CW-1:0] : diff[CW-1:0];
		cmmag = cm[CW] ? cmneg[CW-1:0] : cm[CW-1:0];
		case (func_q)
			FN_INTERSECT: begin
				if (ck < pk)
					sqmag = dmag;
				else if (ck > mk)
					sqmag = cmmag;
				else
					sqmag = '0;
			end
			FN_CONTAIN: sqmag = (dmag > cmmag) ? dmag : cmmag;
			default:    sqmag = dmag;
		endcase
		num = root_q - (CW+1)'(radius_q);
		case (cmd.mul_sel)
			MUL_MOVE: begin
				ma = dmag;
				mb = num;
			end
			MUL_RSQ: begin
				ma = CW'(radius_q);
				mb = (CW+1)'(radius_q);
			end
			default: begin
				ma = sqmag;
				mb = (CW+1)'(sqmag);
			end
		endcase
		srn    = {srem_q[SRW-3:0], src_q[AW-1:AW-2]};
		strial = SRW'({root_q, 2'b01});
		drn    = {drem_q[DRW-2:0], dsrc_q[CW-1]};
		dden   = DRW'({root_q, 1'b0});
		if (diff[CW])
			newc = {ck[CW-1], ck} - {1'b0, quo_q};
		else
			newc = {ck[CW-1], ck} + {1'b0, quo_q};
		sumlr  = (CW+2)'(root_q) + (CW+2)'(radius_q);
		half   = sumlr[CW+1:1];
		nr     = (half[CW] | half[CW-1]) ? '1 : half[CW-2:0];
		lr_sat = (lr_q > RMAX31) ? '1 : lr_q[CW-2:0];
	end

	assign stat.func = func_q;
	assign stat.grow = acc_q > AW'(rsq_q);
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				c_q[i] <= '0;
			radius_q <= '0;
			rsq_q    <= '0;
		end else begin
			if (cmd.load_sphere) begin
				for (int i = 0; i < 3; i++)
					c_q[i] <= p_q[i];
				radius_q <= lr_sat;
			end
			if (cmd.move_en) begin
				if (newc[CW] != newc[CW-1])
					c_q[cmd.axis] <= newc[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
				else
					c_q[cmd.axis] <= newc[CW-1:0];
			end
			if (cmd.rad_update)
				radius_q <= nr;
			if (cmd.rsq_wr)
				rsq_q <= prod_q[2*CW-3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= item.func;
			p_q[0] <= item.point_x[CW-1:0];
			p_q[1] <= item.point_y[CW-1:0];
			p_q[2] <= item.point_z[CW-1:0];
			m_q[0] <= item.max_x[CW-1:0];
			m_q[1] <= item.max_y[CW-1:0];
			m_q[2] <= item.max_z[CW-1:0];
			lr_q   <= item.load_radius;
			acc_q  <= '0;
			flag_q <= 1'b0;
		end
		prod_q <= PW'(ma * mb);
		if (cmd.acc_en)
			acc_q <= acc_q + AW'(prod_q);
		if (cmd.flag_en)
			flag_q <= !stat.grow;
		if (cmd.sqrt_init) begin
			src_q  <= acc_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			src_q <= {src_q[AW-3:0], 2'b00};
			if (srn >= strial) begin
				srem_q <= srn - strial;
				root_q <= {root_q[CW-1:0], 1'b1};
			end else begin
				srem_q <= srn;
				root_q <= {root_q[CW-1:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			drem_q <= DRW'(prod_q[PW-1:CW]);
			dsrc_q <= prod_q[CW-1:0];
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			dsrc_q <= {dsrc_q[CW-2:0], 1'b0};
			if (drn >= dden) begin
				drem_q <= drn - dden;
				quo_q  <= {quo_q[CW-2:0], 1'b1};
			end else begin
				drem_q <= drn;
				quo_q  <= {quo_q[CW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			result_q.test_flag    <= flag_q;
			result_q.out_center_x <= 32'(c_q[0]);
			result_q.out_center_y <= 32'(c_q[1]);
			result_q.out_center_z <= 32'(c_q[2]);
			result_q.out_radius   <= 31'(radius_q);
		end
	end

endmodule

// ===== sv/bsu_ctrl.sv =====
// Controller of the bounding sphere unit: sequences one request through the
// datapath and owns the handshakes. Depends on bsu_pkg.
module bsu_ctrl import bsu_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t stat,
	output cmd_t    cmd
);
	localparam int CNTW = $clog2(CW + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_SQ_MUL, ST_SQ_ACC, ST_CHECK, ST_SQRT, ST_MV_MUL,
		ST_DIV_INIT, ST_DIV, ST_MV_APPLY, ST_RAD, ST_RSQ_MUL, ST_RSQ_WR, ST_FIN
	} state_t;

	state_t          state_q;
	logic [1:0]      axis_q;
	logic [CNTW-1:0] cnt_q;
	logic            result_valid_q;
	logic            out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.axis        = axis_q;
		cmd.mul_sel     = MUL_SQ;
		cmd.capture     = state_q == ST_IDLE && item_valid;
		cmd.load_sphere = state_q == ST_LOAD;
		cmd.acc_en      = state_q == ST_SQ_ACC;
		cmd.flag_en     = state_q == ST_CHECK &&
			(stat.func == FN_INTERSECT || stat.func == FN_CONTAIN);
		cmd.sqrt_init   = state_q == ST_CHECK && stat.func == FN_ENCAP && stat.grow;
		cmd.sqrt_step   = state_q == ST_SQRT;
		cmd.div_init    = state_q == ST_DIV_INIT;
		cmd.div_step    = state_q == ST_DIV;
		cmd.move_en     = state_q == ST_MV_APPLY;
		cmd.rad_update  = state_q == ST_RAD;
		cmd.rsq_wr      = state_q == ST_RSQ_WR;
		cmd.out_load    = state_q == ST_FIN && out_free;
		case (state_q)
			ST_MV_MUL:  cmd.mul_sel = MUL_MOVE;
			ST_RSQ_MUL: cmd.mul_sel = MUL_RSQ;
			default:    cmd.mul_sel = MUL_SQ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			axis_q         <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					if (item_valid)
						state_q <= ST_SQ_MUL;
				end
				ST_SQ_MUL: begin
					state_q <= (stat.func == FN_LOAD) ? ST_LOAD : ST_SQ_ACC;
				end
				ST_LOAD:   state_q <= ST_RSQ_MUL;
				ST_SQ_ACC: begin
					if (axis_q == 2'd2) begin
						state_q <= ST_CHECK;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_CHECK: begin
					cnt_q  <= '0;
					axis_q <= '0;
					if (stat.func == FN_ENCAP && stat.grow)
						state_q <= ST_SQRT;
					else
						state_q <= ST_FIN;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(CW))
						state_q <= ST_MV_MUL;
				end
				ST_MV_MUL:   state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(CW - 1))
						state_q <= ST_MV_APPLY;
				end
				ST_MV_APPLY: begin
					if (axis_q == 2'd2) begin
						state_q <= ST_RAD;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MV_MUL;
					end
				end
				ST_RAD:     state_q <= ST_RSQ_MUL;
				ST_RSQ_MUL: state_q <= ST_RSQ_WR;
				ST_RSQ_WR:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
